// ----- rtl/core/vafvz_pkg.sv -----
`timescale 1ns / 1ps

package vafvz_pkg;

	// Default geometry
	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int DECIMATION_DEF    = 5;

	// Field widths
	localparam int ALT_W     = 22;
	localparam int REP_W     = 21;
	localparam int SPEED_W   = 22;
	localparam int COEF_W    = 16;
	localparam int HSEC_W    = 7;
	localparam int FRAC_BITS = 16;
	localparam int FILT_W    = 40;

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_COEF = 2'd0;
	localparam logic [1:0] REG_HSEC = 2'd1;
	localparam logic [1:0] REG_GOFF = 2'd2;

	localparam logic [COEF_W-1:0] COEF_RST = 16'd52429;
	localparam logic [HSEC_W-1:0] HSEC_RST = 7'd5;

	// Valid reporting window, whole centimetres
	localparam longint FAULT_HIGH_CM = 999900;
	localparam longint FAULT_LOW_CM  = -50000;

endpackage

// ----- rtl/core/vario_altitude_filter_vz_unit.sv -----
`timescale 1ns / 1ps

// Altitude smoothing filter with vertical-speed estimate.
//
// Samples enter on altitude_cm with in_valid / in_ready; one result leaves per
// sample on out_valid / out_ready carrying reported_alt_cm, alt_fault,
// vert_speed_cms and speed_updated. Registers sit on an APB-style port:
// filter_coef at 0x0, history_seconds at 0x4, ground_offset_cm at 0x8.
//
// One sample is worked on at a time. After the accepting edge the seeding
// sample passes through SEED, a plain filtered sample through MUL1, MUL2 and
// FILT, and a sample that updates the speed history further through PUSH,
// DIFF, DIV and SIGN; each result is then registered in RPT, which returns to
// IDLE for the next transfer. The speed update comes from the bit-serial divider
// (one quotient bit a cycle over 22 bits) that follows the history memory read.
//
// A finished result waits in the output register while the next sample is
// accepted; if the receiver stalls, the following sample completes its work
// and holds until the output register frees. Reset clears the filter, the
// counters and the registers to their defaults; the history memory is not
// cleared and entries not yet written are covered by the seed value.

module vario_altitude_filter_vz_unit #(
	parameter int HISTORY_DEPTH = vafvz_pkg::HISTORY_DEPTH_DEF,
	parameter int DECIMATION    = vafvz_pkg::DECIMATION_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [vafvz_pkg::ALT_W-1:0]   altitude_cm,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [vafvz_pkg::REP_W-1:0]   reported_alt_cm,
	output logic                                alt_fault,
	output logic signed [vafvz_pkg::SPEED_W-1:0] vert_speed_cms,
	output logic                                speed_updated,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vafvz_pkg::ADDR_W-1:0]         paddr,
	input  logic [vafvz_pkg::DATA_W-1:0]         pwdata,
	output logic [vafvz_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);

	localparam int ALT_W   = vafvz_pkg::ALT_W;
	localparam int REP_W   = vafvz_pkg::REP_W;
	localparam int SPEED_W = vafvz_pkg::SPEED_W;
	localparam int COEF_W  = vafvz_pkg::COEF_W;
	localparam int HSEC_W  = vafvz_pkg::HSEC_W;
	localparam int FRAC    = vafvz_pkg::FRAC_BITS;
	localparam int FILT_W  = vafvz_pkg::FILT_W;

	localparam int AW  = $clog2(HISTORY_DEPTH);
	localparam int NW  = $clog2(HISTORY_DEPTH + 1);
	localparam int CW  = (NW > HSEC_W) ? NW : HSEC_W;
	localparam int PW  = AW + 2;
	localparam int DW  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam int P1_W = FILT_W + COEF_W + 1;
	localparam int P2_W = ALT_W + COEF_W + 2;
	localparam int SUM_W = FILT_W + 1;
	localparam int DCW = $clog2(SPEED_W);

	localparam logic signed [SUM_W-1:0] FAULT_HI_Q =
		SUM_W'(vafvz_pkg::FAULT_HIGH_CM * 65536);
	localparam logic signed [SUM_W-1:0] FAULT_LO_Q =
		SUM_W'(vafvz_pkg::FAULT_LOW_CM * 65536);
	localparam logic signed [FILT_W-1:0] HALF_F = FILT_W'(longint'(1) << (FRAC - 1));
	localparam logic signed [SUM_W-1:0]  HALF_S = SUM_W'(longint'(1) << (FRAC - 1));

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SEED = 4'd1;
	localparam logic [3:0] S_MUL1 = 4'd2;
	localparam logic [3:0] S_MUL2 = 4'd3;
	localparam logic [3:0] S_FILT = 4'd4;
	localparam logic [3:0] S_PUSH = 4'd5;
	localparam logic [3:0] S_DIFF = 4'd6;
	localparam logic [3:0] S_DIV  = 4'd7;
	localparam logic [3:0] S_SIGN = 4'd8;
	localparam logic [3:0] S_RPT  = 4'd9;

	// configuration registers
	logic [COEF_W-1:0]       coef_q;
	logic [HSEC_W-1:0]       hsec_q;
	logic signed [ALT_W-1:0] goff_q;

	// control and filter state
	logic [3:0]               state_q;
	logic                     seeded_q;
	logic                     dropped_q;
	logic [DW-1:0]            decim_q;
	logic [NW-1:0]            fill_q;
	logic [AW-1:0]            wp_q;
	logic signed [FILT_W-1:0] filtered_q;
	logic signed [ALT_W-1:0]  seed_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic                     upd_q;
	logic [DCW-1:0]           dcnt_q;

	// datapath registers
	logic signed [ALT_W-1:0]  x_q;
	logic signed [P1_W-1:0]   p1_q;
	logic signed [P2_W-1:0]   p2_q;
	logic signed [ALT_W-1:0]  newest_q;
	logic [NW-1:0]            n_q;
	logic                     use_mem_q;
	logic                     neg_q;
	logic [NW-1:0]            rem_q;
	logic [SPEED_W-1:0]       quo_q;

	// output register
	logic                      out_valid_q;
	logic signed [REP_W-1:0]   rep_q;
	logic                      fault_q;
	logic signed [SPEED_W-1:0] speed_out_q;
	logic                      upd_out_q;

	// history memory
	logic signed [ALT_W-1:0] hist_mem [HISTORY_DEPTH];
	logic signed [ALT_W-1:0] rd_data_q;

	logic                     cfg_wr;
	logic [COEF_W:0]          wgt;
	logic signed [SUM_W-1:0]  filt_new;
	logic signed [FILT_W-1:0] filt_rnd;
	logic signed [ALT_W-1:0]  newest;
	logic [NW-1:0]            n_val;
	logic [NW-1:0]            fill_next;
	logic [PW-1:0]            rd_sum;
	logic [AW-1:0]            rd_addr;
	logic signed [ALT_W-1:0]  oldest;
	logic signed [ALT_W:0]    diff;
	logic [NW:0]              rem_sh;
	logic                     rem_ge;
	logic signed [ALT_W-1:0]  off_val;
	logic signed [SUM_W-1:0]  rpt_sum;
	logic signed [SUM_W-1:0]  rpt_rnd;
	logic                     rpt_fault;
	logic                     rpt_go;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_ready = (state_q == S_IDLE);

	assign out_valid       = out_valid_q;
	assign reported_alt_cm = rep_q;
	assign alt_fault       = fault_q;
	assign vert_speed_cms  = speed_out_q;
	assign speed_updated   = upd_out_q;

	always_comb begin
		unique case (paddr[3:2])
			vafvz_pkg::REG_COEF: prdata = vafvz_pkg::DATA_W'(coef_q);
			vafvz_pkg::REG_HSEC: prdata = vafvz_pkg::DATA_W'(hsec_q);
			vafvz_pkg::REG_GOFF: prdata = vafvz_pkg::DATA_W'(goff_q);
			default:             prdata = '0;
		endcase
	end

	// filter arithmetic: floor(acc / 2^16) = floor(f*c / 2^16) + x*(2^16 - c)
	assign wgt      = ((COEF_W + 1)'(1) << COEF_W) - (COEF_W + 1)'(coef_q);
	assign filt_new = $signed(p1_q[P1_W-1:FRAC]) + SUM_W'(p2_q);
	assign filt_rnd = filtered_q + HALF_F;
	assign newest   = filt_rnd[FRAC+ALT_W-1:FRAC];

	// effective history length, clamped to 1..HISTORY_DEPTH
	always_comb begin
		if (hsec_q == '0) begin
			n_val = NW'(1);
		end else if (CW'(hsec_q) > CW'(HISTORY_DEPTH)) begin
			n_val = NW'(HISTORY_DEPTH);
		end else begin
			n_val = NW'(hsec_q);
		end
	end

	assign fill_next = (fill_q < NW'(HISTORY_DEPTH)) ? fill_q + NW'(1) : fill_q;

	// entry n-1 pushes before the one being written
	assign rd_sum  = PW'(wp_q) + PW'(HISTORY_DEPTH) - PW'(n_val) + PW'(1);
	assign rd_addr = (rd_sum >= PW'(HISTORY_DEPTH)) ? AW'(rd_sum - PW'(HISTORY_DEPTH))
	                                                : AW'(rd_sum);

	always_comb begin
		if (n_q == NW'(1)) begin
			oldest = newest_q;
		end else if (use_mem_q) begin
			oldest = rd_data_q;
		end else begin
			oldest = seed_q;
		end
	end

	assign diff   = (ALT_W + 1)'(newest_q) - (ALT_W + 1)'(oldest);
	assign rem_sh = {rem_q, quo_q[SPEED_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, n_q});

	assign off_val   = dropped_q ? '0 : goff_q;
	assign rpt_sum   = SUM_W'(filtered_q) + (SUM_W'(off_val) <<< FRAC);
	assign rpt_rnd   = rpt_sum + HALF_S;
	assign rpt_fault = (rpt_sum > FAULT_HI_Q) || (rpt_sum < FAULT_LO_Q);
	assign rpt_go    = (state_q == S_RPT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH) begin
			hist_mem[wp_q] <= newest;
		end
		rd_data_q <= hist_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q <= altitude_cm;
		end
		if (state_q == S_MUL1) begin
			p1_q <= filtered_q * $signed({1'b0, coef_q});
		end
		if (state_q == S_MUL2) begin
			p2_q <= x_q * $signed({1'b0, wgt});
		end
		if (state_q == S_PUSH) begin
			newest_q  <= newest;
			n_q       <= n_val;
			use_mem_q <= (fill_next >= n_val);
		end
		if (rpt_go) begin
			rep_q       <= rpt_fault ? REP_W'(vafvz_pkg::FAULT_HIGH_CM)
			                         : rpt_rnd[FRAC+REP_W-1:FRAC];
			fault_q     <= rpt_fault;
			speed_out_q <= speed_q;
			upd_out_q   <= upd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q      <= vafvz_pkg::COEF_RST;
			hsec_q      <= vafvz_pkg::HSEC_RST;
			goff_q      <= '0;
			state_q     <= S_IDLE;
			seeded_q    <= 1'b0;
			dropped_q   <= 1'b0;
			decim_q     <= '0;
			fill_q      <= '0;
			wp_q        <= '0;
			filtered_q  <= '0;
			seed_q      <= '0;
			speed_q     <= '0;
			upd_q       <= 1'b0;
			dcnt_q      <= '0;
			neg_q       <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (paddr[3:2])
					vafvz_pkg::REG_COEF: coef_q <= pwdata[COEF_W-1:0];
					vafvz_pkg::REG_HSEC: hsec_q <= pwdata[HSEC_W-1:0];
					vafvz_pkg::REG_GOFF: begin
						goff_q    <= $signed(pwdata[ALT_W-1:0]);
						dropped_q <= 1'b0;
					end
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= seeded_q ? S_MUL1 : S_SEED;
					end
				end
				S_SEED: begin
					filtered_q <= FILT_W'(x_q) <<< FRAC;
					seed_q     <= x_q;
					seeded_q   <= 1'b1;
					upd_q      <= 1'b0;
					state_q    <= S_RPT;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_FILT;
				S_FILT: begin
					filtered_q <= filt_new[FILT_W-1:0];
					upd_q      <= (decim_q == '0);
					decim_q    <= (decim_q == DW'(DECIMATION - 1)) ? '0 : decim_q + DW'(1);
					state_q    <= (decim_q == '0) ? S_PUSH : S_RPT;
				end
				S_PUSH: begin
					fill_q  <= fill_next;
					wp_q    <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					neg_q   <= diff[ALT_W];
					quo_q   <= diff[ALT_W] ? SPEED_W'(-diff) : SPEED_W'(diff);
					rem_q   <= '0;
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					rem_q  <= rem_ge ? NW'(rem_sh - {1'b0, n_q}) : NW'(rem_sh);
					quo_q  <= {quo_q[SPEED_W-2:0], rem_ge};
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(SPEED_W - 1)) begin
						state_q <= S_SIGN;
					end
				end
				S_SIGN: begin
					speed_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
					state_q <= S_RPT;
				end
				S_RPT: begin
					if (rpt_go) begin
						out_valid_q <= 1'b1;
						if (rpt_fault) begin
							dropped_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted while previous sample in progress");

	a_fault_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alt_fault |-> reported_alt_cm == REP_W'(vafvz_pkg::FAULT_HIGH_CM))
		else $error("fault result without replacement altitude");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NW'(HISTORY_DEPTH) && wp_q <= AW'(HISTORY_DEPTH - 1))
		else $error("history fill or write pointer out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> n_q != '0)
		else $error("divider running with zero history length");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RPT && out_valid_q && !out_ready |=> state_q == S_RPT)
		else $error("result left report state while output register full");

endmodule

// ----- test/vario_altitude_filter_vz_unit_test.sv -----
`timescale 1ns / 1ps

typedef struct {
	logic signed [vafvz_pkg::REP_W-1:0]   alt_cm;
	logic                                 fault;
	logic signed [vafvz_pkg::SPEED_W-1:0] speed_cms;
	logic                                 updated;
} vz_result_t;

class altitude_speed_tracker;
	localparam int DEPTH = vafvz_pkg::HISTORY_DEPTH_DEF;
	localparam int DECIM = vafvz_pkg::DECIMATION_DEF;
	localparam longint ONE_Q16 = longint'(1) << vafvz_pkg::FRAC_BITS;
	localparam longint HALF_Q16 = longint'(1) << (vafvz_pkg::FRAC_BITS - 1);

	// register mirror
	logic [vafvz_pkg::COEF_W-1:0]        coef;
	logic [vafvz_pkg::HSEC_W-1:0]        hist_len;
	logic signed [vafvz_pkg::ALT_W-1:0]  ground_off;

	// filter and history state
	bit     seeded;
	longint filt_q16;
	int     decim_cnt;
	longint hist_cm[DEPTH];
	int     hist_fill;
	longint seed_cm;
	int     wr_ptr;
	longint speed_cms;
	bit     off_dropped;

	vz_result_t pending_results[$];
	int mismatches;
	int results_seen;
	int speed_updates;
	int faults_seen;

	function new();
		coef = vafvz_pkg::COEF_RST;
		hist_len = vafvz_pkg::HSEC_RST;
		ground_off = '0;
		seeded = 0;
		filt_q16 = 0;
		decim_cnt = 0;
		hist_fill = 0;
		seed_cm = 0;
		wr_ptr = 0;
		speed_cms = 0;
		off_dropped = 0;
		mismatches = 0;
		results_seen = 0;
		speed_updates = 0;
		faults_seen = 0;
	endfunction

	function void set_register(logic [1:0] idx, logic [31:0] value);
		case (idx)
			vafvz_pkg::REG_COEF: coef = value[vafvz_pkg::COEF_W-1:0];
			vafvz_pkg::REG_HSEC: hist_len = value[vafvz_pkg::HSEC_W-1:0];
			vafvz_pkg::REG_GOFF: begin
				ground_off = value[vafvz_pkg::ALT_W-1:0];
				off_dropped = 0;
			end
			default: ;
		endcase
	endfunction

	function void note_sample(logic signed [vafvz_pkg::ALT_W-1:0] sample);
		longint x;
		longint c;
		longint newest;
		longint oldest;
		longint off;
		longint sum;
		longint rep;
		int n;
		vz_result_t e;
		x = sample;
		e.updated = 0;
		e.fault = 0;
		if (!seeded) begin
			seeded = 1;
			filt_q16 = x * ONE_Q16;
			seed_cm = x;
		end else begin
			c = coef;
			filt_q16 = (filt_q16 * c + (x * ONE_Q16) * (ONE_Q16 - c))
				>>> vafvz_pkg::FRAC_BITS;
			if (decim_cnt == 0) begin
				n = hist_len;
				if (n < 1) n = 1;
				if (n > DEPTH) n = DEPTH;
				newest = (filt_q16 + HALF_Q16) >>> vafvz_pkg::FRAC_BITS;
				hist_cm[wr_ptr] = newest;
				if (hist_fill < DEPTH) hist_fill++;
				// entries older than the pushes so far read as the seed
				if (hist_fill >= n)
					oldest = hist_cm[(wr_ptr + DEPTH - (n - 1)) % DEPTH];
				else
					oldest = seed_cm;
				speed_cms = (newest - oldest) / n;
				wr_ptr = (wr_ptr + 1) % DEPTH;
				e.updated = 1;
			end
			decim_cnt = (decim_cnt + 1 >= DECIM) ? 0 : decim_cnt + 1;
		end
		off = off_dropped ? 0 : longint'(ground_off);
		sum = filt_q16 + off * ONE_Q16;
		if (sum > vafvz_pkg::FAULT_HIGH_CM * ONE_Q16 ||
				sum < vafvz_pkg::FAULT_LOW_CM * ONE_Q16) begin
			e.fault = 1;
			off_dropped = 1;
			rep = vafvz_pkg::FAULT_HIGH_CM;
		end else begin
			rep = (sum + HALF_Q16) >>> vafvz_pkg::FRAC_BITS;
		end
		e.alt_cm = rep[vafvz_pkg::REP_W-1:0];
		e.speed_cms = speed_cms[vafvz_pkg::SPEED_W-1:0];
		pending_results.push_back(e);
	endfunction

	function void check_result(vz_result_t got);
		vz_result_t e;
		results_seen++;
		if (got.updated === 1'b1) speed_updates++;
		if (got.fault === 1'b1) faults_seen++;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result: alt %0d flt %0b vz %0d upd %0b",
					$realtime, got.alt_cm, got.fault, got.speed_cms, got.updated);
			return;
		end
		e = pending_results.pop_front();
		if (got.alt_cm !== e.alt_cm || got.fault !== e.fault ||
				got.speed_cms !== e.speed_cms || got.updated !== e.updated) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: exp alt %0d flt %0b vz %0d upd %0b / got %0d %0b %0d %0b",
					$realtime, e.alt_cm, e.fault, e.speed_cms, e.updated,
					got.alt_cm, got.fault, got.speed_cms, got.updated);
		end
	endfunction

	function int pending();
		return pending_results.size();
	endfunction
endclass

module vario_altitude_filter_vz_unit_test;
	localparam logic [1:0] REG_NONE = 2'd3;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_SAMPLES = 110;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [vafvz_pkg::ALT_W-1:0] altitude_cm;
	logic out_valid;
	logic out_ready;
	logic signed [vafvz_pkg::REP_W-1:0] reported_alt_cm;
	logic alt_fault;
	logic signed [vafvz_pkg::SPEED_W-1:0] vert_speed_cms;
	logic speed_updated;
	logic psel;
	logic penable;
	logic pwrite;
	logic [vafvz_pkg::ADDR_W-1:0] paddr;
	logic [vafvz_pkg::DATA_W-1:0] pwdata;
	logic [vafvz_pkg::DATA_W-1:0] prdata;
	logic pready;

	altitude_speed_tracker sb;
	vz_result_t seen;
	bit steady;
	int walk_cm;
	int samples_sent;
	int settings_used;
	int stall_left;

	vario_altitude_filter_vz_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.altitude_cm(altitude_cm),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.reported_alt_cm(reported_alt_cm),
		.alt_fault(alt_fault),
		.vert_speed_cms(vert_speed_cms),
		.speed_updated(speed_updated),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// check the result first; a sample taken at this edge cannot have produced it
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			seen.alt_cm = reported_alt_cm;
			seen.fault = alt_fault;
			seen.speed_cms = vert_speed_cms;
			seen.updated = speed_updated;
			sb.check_result(seen);
		end
		if (in_valid && in_ready) sb.note_sample(altitude_cm);
	end

	// receiver: random stalls with occasional long holds, always ready in the steady phase
	initial begin
		out_ready = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (steady) begin
				out_ready <= 1;
			end else if (stall_left > 0) begin
				out_ready <= 0;
				stall_left--;
			end else if ($urandom_range(0, 999) < 2) begin
				stall_left = $urandom_range(10, 40);
				out_ready <= 0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 35);
			end
		end
	end

	task automatic send_sample(input logic signed [vafvz_pkg::ALT_W-1:0] value);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 99) < 35)
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		altitude_cm <= value;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
	endtask

	// drop valid and hold until every transfer has its result back
	task automatic wait_drained();
		in_valid <= 0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		sb.set_register(idx, value);
	endtask

	function automatic logic signed [vafvz_pkg::ALT_W-1:0] next_altitude();
		int r;
		logic [31:0] raw;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			walk_cm += int'($urandom_range(0, 600)) - 300;
			if (walk_cm < -100000) walk_cm = -100000;
			if (walk_cm > 1500000) walk_cm = 1500000;
			return walk_cm[vafvz_pkg::ALT_W-1:0];
		end
		if (r < 92) begin
			walk_cm = int'($urandom_range(0, 1600000)) - 100000;
			return walk_cm[vafvz_pkg::ALT_W-1:0];
		end
		if (r < 97) begin
			raw = $urandom;
			return raw[vafvz_pkg::ALT_W-1:0];
		end
		case ($urandom_range(0, 3))
			0: return {1'b1, {(vafvz_pkg::ALT_W-1){1'b0}}};
			1: return {1'b0, {(vafvz_pkg::ALT_W-1){1'b1}}};
			2: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic pick_settings();
		int r;
		int v;
		logic [vafvz_pkg::COEF_W-1:0] coef;
		logic [vafvz_pkg::HSEC_W-1:0] hsec;
		logic signed [vafvz_pkg::ALT_W-1:0] off;
		logic [31:0] raw;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			coef = '0;
		end else if (r < 30) begin
			coef = '1;
		end else if (r < 70) begin
			raw = $urandom_range(45000, 65000);
			coef = raw[vafvz_pkg::COEF_W-1:0];
		end else begin
			raw = $urandom_range(0, 65535);
			coef = raw[vafvz_pkg::COEF_W-1:0];
		end
		r = $urandom_range(0, 99);
		if (r < 10) begin
			hsec = '0;
		end else if (r < 20) begin
			raw = $urandom_range(65, 127);
			hsec = raw[vafvz_pkg::HSEC_W-1:0];
		end else begin
			raw = $urandom_range(1, 64);
			hsec = raw[vafvz_pkg::HSEC_W-1:0];
		end
		r = $urandom_range(0, 99);
		raw = $urandom;
		v = int'($urandom_range(0, 200000)) - 100000;
		if (r < 60) off = v[vafvz_pkg::ALT_W-1:0];
		else if (r < 80) off = '0;
		else off = raw[vafvz_pkg::ALT_W-1:0];
		if ($urandom_range(0, 9) < 7) write_register(vafvz_pkg::REG_COEF, 32'(coef));
		if ($urandom_range(0, 9) < 7) write_register(vafvz_pkg::REG_HSEC, 32'(hsec));
		if ($urandom_range(0, 9) < 7) write_register(vafvz_pkg::REG_GOFF, 32'(off));
		settings_used++;
	endtask

	initial begin
		#4000000;
		$display("vario_altitude_filter_vz_unit_test: FAIL");
		$finish;
	end

	initial begin
		sb = new();
		clk = 0;
		arst_n = 0;
		in_valid = 0;
		altitude_cm = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		steady = 0;
		walk_cm = 50000;
		samples_sent = 0;
		settings_used = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset settings: seed, then field extremes
		send_sample(50000);
		send_sample(2097151);
		send_sample(-2097152);
		send_sample(0);
		send_sample(-100000);
		send_sample(1500000);
		wait_drained();

		// pass-through filter, single-entry history, fault window edges
		write_register(vafvz_pkg::REG_COEF, 32'd0);
		write_register(vafvz_pkg::REG_HSEC, 32'd1);
		write_register(vafvz_pkg::REG_GOFF, 32'd0);
		write_register(REG_NONE, 32'hFFFF_FFFF);
		settings_used++;
		send_sample(999900);
		send_sample(999901);
		send_sample(-50000);
		send_sample(-50001);
		send_sample(2097151);
		send_sample(-2097152);
		wait_drained();

		write_register(vafvz_pkg::REG_COEF, 32'd65535);
		write_register(vafvz_pkg::REG_HSEC, 32'd64);
		write_register(vafvz_pkg::REG_GOFF, 32'(22'sh1FFFFF));
		settings_used++;
		send_sample(-2097152);
		send_sample(-1500000);
		send_sample(0);
		send_sample(2097151);
		wait_drained();

		// history length zero acts as one
		write_register(vafvz_pkg::REG_COEF, 32'd32768);
		write_register(vafvz_pkg::REG_HSEC, 32'd0);
		write_register(vafvz_pkg::REG_GOFF, 32'(-22'sd2097152));
		settings_used++;
		send_sample(1000);
		send_sample(2000);
		send_sample(3000);
		send_sample(4000);
		send_sample(5000);
		wait_drained();

		// history length beyond the store
		write_register(vafvz_pkg::REG_HSEC, 32'd127);
		write_register(vafvz_pkg::REG_GOFF, 32'd0);
		settings_used++;
		send_sample(50000);
		send_sample(60000);
		send_sample(40000);
		send_sample(50000);
		wait_drained();

		for (int p = 0; p < RAND_PHASES; p++) begin
			pick_settings();
			steady = (p == 3);
			for (int i = 0; i < PHASE_SAMPLES; i++) send_sample(next_altitude());
			wait_drained();
			steady = 0;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d samples over %0d register settings", samples_sent, settings_used);
		$display("checked %0d results: %0d speed updates, %0d range faults",
			sb.results_seen, sb.speed_updates, sb.faults_seen);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("vario_altitude_filter_vz_unit_test: PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
			$display("vario_altitude_filter_vz_unit_test: FAIL");
		end
		$finish;
	end
endmodule

// ----- files.f -----
rtl/core/vafvz_pkg.sv
rtl/core/vario_altitude_filter_vz_unit.sv
test/vario_altitude_filter_vz_unit_test.sv
